// ----- src/pidfd_pkg.sv -----
// Shared types, constants and command codes of the filtered-derivative PID controller.
package pidfd_pkg;

	// Data widths of the Q16.16 datapath.
	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int ACC_W    = 48;
	localparam int ALPHA_W  = 17;
	localparam int ERR_W    = DATA_W + 1;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int BOP_W    = DATA_W + 1;
	localparam int HALF_W   = ACC_W / 2;
	localparam int PP_W     = HALF_W + DATA_W;
	localparam int PROD_W   = ACC_W + DATA_W;
	localparam int DVD_W    = DIFF_W + FRAC_W;
	localparam int CNT_W    = $clog2(DVD_W);
	localparam int IDX_W    = 3;
	localparam int IN_W     = 2 * DATA_W;

	// Saturation limits of the accumulator range.
	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Unity of the smoothing factor (1.0 in Q1.16).
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h1_0000;

	// Register reset values.
	localparam logic [DATA_W-1:0]  RST_PROP_GAIN  = 32'h0001_0000;
	localparam logic [DATA_W-1:0]  RST_INTEG_GAIN = 32'd6554;
	localparam logic [DATA_W-1:0]  RST_DERIV_GAIN = 32'd655;
	localparam logic [DATA_W-1:0]  RST_LIMIT_LOW  = 32'hFFF6_0000;
	localparam logic [DATA_W-1:0]  RST_LIMIT_HIGH = 32'h000A_0000;
	localparam logic [DATA_W-1:0]  RST_PERIOD     = 32'd6554;
	localparam logic [ALPHA_W-1:0] RST_ALPHA      = 17'd52429;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [IDX_W-1:0] REG_LIMIT_LOW    = 3'd3;
	localparam logic [IDX_W-1:0] REG_LIMIT_HIGH   = 3'd4;
	localparam logic [IDX_W-1:0] REG_PERIOD       = 3'd5;
	localparam logic [IDX_W-1:0] REG_FILTER_ALPHA = 3'd6;

	// Multiplier operations, issued in this order for each item.
	localparam logic [2:0] OP_PROP      = 3'd0;
	localparam logic [2:0] OP_INTEG_ADD = 3'd1;
	localparam logic [2:0] OP_INTEG     = 3'd2;
	localparam logic [2:0] OP_FILT_OLD  = 3'd3;
	localparam logic [2:0] OP_FILT_NEW  = 3'd4;
	localparam logic [2:0] OP_DERIV     = 3'd5;

	// Phases of one multiplication.
	localparam logic [2:0] PH_MAG = 3'd0;
	localparam logic [2:0] PH_LO  = 3'd1;
	localparam logic [2:0] PH_HI  = 3'd2;
	localparam logic [2:0] PH_ADD = 3'd3;
	localparam logic [2:0] PH_WB  = 3'd4;

	// Configuration register bank.
	typedef struct packed {
		logic [DATA_W-1:0]  prop_gain;
		logic [DATA_W-1:0]  integ_gain;
		logic [DATA_W-1:0]  deriv_gain;
		logic [DATA_W-1:0]  limit_low;
		logic [DATA_W-1:0]  limit_high;
		logic [DATA_W-1:0]  sample_period;
		logic [ALPHA_W-1:0] filter_alpha;
	} pidfd_cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       clear;
		logic       div_start;
		logic       mul_en;
		logic [2:0] op;
		logic [2:0] ph;
		logic       sum_en;
		logic       emit;
	} pidfd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
	} pidfd_sts_t;

endpackage

// ----- src/pidfd_div.sv -----
// Restoring divider forming the saturated raw slope (difference << FRAC_W) / sample period.
module pidfd_div import pidfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIFF_W-1:0] dvd_mag,
	input  logic              dvd_neg,
	input  logic [DATA_W-1:0] divisor,
	output logic [ACC_W-1:0]  raw,
	output logic              done
);

	logic             busy_q;
	logic             fin_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] n_q;
	logic [DATA_W-1:0] rem_q;
	logic             neg_q;
	logic [ACC_W-1:0] raw_q;

	logic              special;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   trial_sub;
	logic              ge;

	// A zero difference or a zero period needs no iterations.
	assign special   = (dvd_mag == '0) || (divisor == '0);

	// One quotient bit per cycle.
	assign trial     = {rem_q, n_q[DVD_W-1]};
	assign trial_sub = trial - {1'b0, divisor};
	assign ge        = (trial >= {1'b0, divisor});

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !special;
			fin_q  <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end else begin
			fin_q <= 1'b0;
		end
	end

	// Dividend and quotient share one shift register; the slope saturates at the end.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {dvd_mag, FRAC_W'(0)};
			rem_q <= '0;
			neg_q <= dvd_neg;
			if (dvd_mag == '0) begin
				raw_q <= '0;
			end else if (divisor == '0) begin
				raw_q <= dvd_neg ? ACC_MIN : ACC_MAX;
			end
		end else if (busy_q) begin
			n_q   <= {n_q[DVD_W-2:0], ge};
			rem_q <= ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
		end else if (fin_q) begin
			if (|n_q[DVD_W-1:ACC_W-1]) begin
				raw_q <= neg_q ? ACC_MIN : ACC_MAX;
			end else begin
				raw_q <= neg_q ? -n_q[ACC_W-1:0] : n_q[ACC_W-1:0];
			end
		end
	end

	assign raw  = raw_q;
	assign done = !busy_q && !fin_q;

	// A new division never starts over one still running.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !fin_q))
		else $error("divider started while busy");

endmodule

// ----- src/pidfd_datapath.sv -----
// Datapath: error, shared multiplier, integrator, derivative filter, sum and clamp.
module pidfd_datapath import pidfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pidfd_cfg_t        cfg,
	input  pidfd_cmd_t        cmd,
	input  logic [DATA_W-1:0] target_value,
	input  logic [DATA_W-1:0] measured_level,
	output pidfd_sts_t        sts,
	output logic [DATA_W-1:0] control_output
);

	// Saturate a shifted product magnitude to the accumulator range with a sign.
	function automatic logic [ACC_W-1:0] sat_mag(input logic [PROD_W-FRAC_W-1:0] m,
	                                             input logic neg);
		if (|m[PROD_W-FRAC_W-1:ACC_W-1]) begin
			return neg ? ACC_MIN : ACC_MAX;
		end
		return neg ? -m[ACC_W-1:0] : m[ACC_W-1:0];
	endfunction

	// Saturating addition of two accumulator values.
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
	                                             input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	// Item and state registers.
	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  last_q;
	logic signed [ACC_W-1:0]  integ_q;
	logic signed [ACC_W-1:0]  fs_q;
	logic signed [ACC_W-1:0]  p_q;
	logic signed [ACC_W-1:0]  i_q;
	logic signed [ACC_W-1:0]  d_q;
	logic signed [ACC_W-1:0]  f1_q;
	logic                     p_in_q;
	logic signed [ACC_W+1:0]  sum_q;
	logic [DATA_W-1:0]        result_q;

	// Multiplier registers.
	logic [ACC_W-1:0]  ma_q;
	logic [DATA_W-1:0] mb_q;
	logic              neg_q;
	logic [PP_W-1:0]   pp_q;
	logic [PROD_W-1:0] acc_q;

	logic signed [ACC_W-1:0] opa;
	logic signed [BOP_W-1:0] opb;
	logic [ACC_W-1:0]        mag_a;
	logic [BOP_W-1:0]        mag_b;
	logic [ALPHA_W-1:0]      alpha_c;
	logic [ALPHA_W-1:0]      alpha_inv;
	logic [ACC_W-1:0]        wb;
	logic signed [ACC_W-1:0] lim_lo_a;
	logic signed [ACC_W-1:0] lim_hi_a;
	logic signed [ACC_W+1:0] lim_lo_s;
	logic signed [ACC_W+1:0] lim_hi_s;
	logic signed [ACC_W+1:0] capped;
	logic signed [ACC_W+1:0] clamped;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]       diff_mag;
	logic [ACC_W-1:0]        raw;
	logic                    div_done;

	// Smoothing factor limited to one, and its complement.
	assign alpha_c   = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
	assign alpha_inv = ALPHA_ONE - alpha_c;

	assign lim_lo_a = ACC_W'($signed(cfg.limit_low));
	assign lim_hi_a = ACC_W'($signed(cfg.limit_high));
	assign lim_lo_s = (ACC_W+2)'($signed(cfg.limit_low));
	assign lim_hi_s = (ACC_W+2)'($signed(cfg.limit_high));

	// Operand selection for the shared multiplier.
	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.op)
			OP_PROP: begin
				opa = ACC_W'(err_q);
				opb = BOP_W'($signed(cfg.prop_gain));
			end
			OP_INTEG_ADD: begin
				opa = ACC_W'(err_q);
				opb = BOP_W'(cfg.sample_period);
			end
			OP_INTEG: begin
				opa = integ_q;
				opb = BOP_W'($signed(cfg.integ_gain));
			end
			OP_FILT_OLD: begin
				opa = fs_q;
				opb = BOP_W'(alpha_c);
			end
			OP_FILT_NEW: begin
				opa = $signed(raw);
				opb = BOP_W'(alpha_inv);
			end
			OP_DERIV: begin
				opa = fs_q;
				opb = BOP_W'($signed(cfg.deriv_gain));
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign mag_a = opa[ACC_W-1] ? -opa : opa;
	assign mag_b = opb[BOP_W-1] ? -opb : opb;

	// Product shifted by the fraction bits, truncated toward zero and saturated.
	assign wb = sat_mag(acc_q[PROD_W-1:FRAC_W], neg_q);

	// Error difference for the slope divider.
	assign diff     = DIFF_W'(err_q) - DIFF_W'(last_q);
	assign diff_mag = diff[DIFF_W-1] ? -diff : diff;

	pidfd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dvd_mag (diff_mag),
		.dvd_neg (diff[DIFF_W-1]),
		.divisor (cfg.sample_period),
		.raw     (raw),
		.done    (div_done)
	);

	assign sts.div_done = div_done;

	// Output clamp: cap at the high limit first, then raise to the low limit.
	assign capped  = (sum_q > lim_hi_s) ? lim_hi_s : sum_q;
	assign clamped = (capped < lim_lo_s) ? lim_lo_s : capped;

	// Multiplier phases, term registers, sum and result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= ERR_W'($signed(target_value)) - ERR_W'($signed(measured_level));
		end
		if (cmd.mul_en) begin
			case (cmd.ph)
				PH_MAG: begin
					ma_q   <= mag_a;
					mb_q   <= mag_b[DATA_W-1:0];
					neg_q  <= opa[ACC_W-1] ^ opb[BOP_W-1];
					p_in_q <= (lim_lo_a < p_q) && (p_q < lim_hi_a);
				end
				PH_LO: begin
					pp_q <= PP_W'(ma_q[HALF_W-1:0]) * PP_W'(mb_q);
				end
				PH_HI: begin
					acc_q <= PROD_W'(pp_q);
					pp_q  <= PP_W'(ma_q[ACC_W-1:HALF_W]) * PP_W'(mb_q);
				end
				PH_ADD: begin
					acc_q <= acc_q + {pp_q, HALF_W'(0)};
				end
				PH_WB: begin
					case (cmd.op)
						OP_PROP:     p_q  <= wb;
						OP_INTEG:    i_q  <= wb;
						OP_FILT_OLD: f1_q <= wb;
						OP_DERIV:    d_q  <= wb;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (cmd.sum_en) begin
			sum_q <= (ACC_W+2)'(p_q) + (ACC_W+2)'(i_q) + (ACC_W+2)'(d_q);
		end
		if (cmd.emit) begin
			result_q <= clamped[DATA_W-1:0];
		end
	end

	// Controller state: integrator, filtered slope and previous error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			fs_q    <= '0;
			last_q  <= '0;
		end else if (cmd.clear) begin
			integ_q <= '0;
			fs_q    <= '0;
			last_q  <= '0;
		end else begin
			if (cmd.mul_en && (cmd.ph == PH_WB) && (cmd.op == OP_INTEG_ADD) && p_in_q) begin
				integ_q <= sat_add(integ_q, wb);
			end
			if (cmd.mul_en && (cmd.ph == PH_WB) && (cmd.op == OP_FILT_NEW)) begin
				fs_q <= sat_add(f1_q, wb);
			end
			if (cmd.emit) begin
				last_q <= err_q;
			end
		end
	end

	assign control_output = result_q;

	// With ordered limits the emitted value always lies between them.
	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && ($signed(cfg.limit_low) <= $signed(cfg.limit_high))) |=>
		(($signed(result_q) >= $signed($past(cfg.limit_low))) &&
		 ($signed(result_q) <= $signed($past(cfg.limit_high)))))
		else $error("control output outside limits");

endmodule

// ----- src/pidfd_ctrl.sv -----
// Controller state machine sequencing the multiplier operations, divider, sum and output.
module pidfd_ctrl import pidfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       mode,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  pidfd_sts_t sts,
	output pidfd_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_CLAMP = 3'd4;

	logic [2:0] state_q;
	logic [2:0] op_q;
	logic [2:0] ph_q;
	logic       out_valid_q;
	logic       accept;
	logic       can_emit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign can_emit = (state_q == ST_CLAMP) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd.load      = accept && !mode;
		cmd.clear     = accept && mode;
		cmd.div_start = (state_q == ST_MUL) && (op_q == OP_PROP) && (ph_q == PH_MAG);
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.op        = op_q;
		cmd.ph        = ph_q;
		cmd.sum_en    = (state_q == ST_SUM);
		cmd.emit      = can_emit;
	end

	// Sequencer: six multiplications of five phases, waiting on the divider before
	// the raw slope is used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_PROP;
			ph_q    <= PH_MAG;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !mode) begin
						state_q <= ST_MUL;
						op_q    <= OP_PROP;
						ph_q    <= PH_MAG;
					end
				end
				ST_MUL: begin
					if (ph_q == PH_WB) begin
						ph_q <= PH_MAG;
						if (op_q == OP_DERIV) begin
							state_q <= ST_SUM;
						end else begin
							op_q <= op_q + 3'd1;
							if ((op_q == OP_FILT_OLD) && !sts.div_done) begin
								state_q <= ST_WAIT;
							end
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				ST_WAIT: begin
					if (sts.div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_SUM: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (can_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register flag: set when a result is written, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The raw slope is never consumed before the divider has finished.
	a_slope_ready: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MUL) && (op_q == OP_FILT_NEW) && (ph_q == PH_MAG)) |-> sts.div_done)
		else $error("raw slope used before division finished");

	// A compute transaction always starts the sequence at its first operation.
	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !mode) |=>
		((state_q == ST_MUL) && (op_q == OP_PROP) && (ph_q == PH_MAG)))
		else $error("compute transaction did not start the sequence");

	// A clear transaction leaves the controller idle.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && mode) |=> (state_q == ST_IDLE))
		else $error("clear transaction left the idle state");

endmodule

// ----- src/pid_controller_filtered_derivative.sv -----
// Top level of the filtered-derivative PID controller: configuration bank, controller, datapath.
// The 50-step slope divider is skipped when the error difference or the sample period is zero.
// A new compute transaction is accepted only once the previous result has been emitted, so a
// held result stalls the next item; a clear transaction is accepted in the idle state.
// Reset: arst_n asynchronously restores the register defaults and zeroes the stored state.
module pid_controller_filtered_derivative import pidfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,    // target_value [31:0], measured_level [63:32]
	input  logic              s_tuser,    // mode [0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,    // control_output [31:0]
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	pidfd_cfg_t cfg_q;
	pidfd_cmd_t cmd;
	pidfd_sts_t sts;

	assign cfg_ready = 1'b1;

	// Configuration register bank; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= RST_PROP_GAIN;
			cfg_q.integ_gain    <= RST_INTEG_GAIN;
			cfg_q.deriv_gain    <= RST_DERIV_GAIN;
			cfg_q.limit_low     <= RST_LIMIT_LOW;
			cfg_q.limit_high    <= RST_LIMIT_HIGH;
			cfg_q.sample_period <= RST_PERIOD;
			cfg_q.filter_alpha  <= RST_ALPHA;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:    cfg_q.prop_gain     <= cfg_data;
				REG_INTEG_GAIN:   cfg_q.integ_gain    <= cfg_data;
				REG_DERIV_GAIN:   cfg_q.deriv_gain    <= cfg_data;
				REG_LIMIT_LOW:    cfg_q.limit_low     <= cfg_data;
				REG_LIMIT_HIGH:   cfg_q.limit_high    <= cfg_data;
				REG_PERIOD:       cfg_q.sample_period <= cfg_data;
				REG_FILTER_ALPHA: cfg_q.filter_alpha  <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	pidfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pidfd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.target_value   (s_tdata[DATA_W-1:0]),
		.measured_level (s_tdata[IN_W-1:DATA_W]),
		.sts            (sts),
		.control_output (m_tdata)
	);

endmodule

// ----- bench/pid_controller_filtered_derivative_tb.sv -----
// Self-checking testbench of the filtered-derivative PID controller with a bit-exact predictor.
module pid_controller_filtered_derivative_tb;
	import pidfd_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE_GAP  = 80;
	localparam int PHASE_ITEMS = 190;
	localparam int ALPHA_FRAC  = 16;

	// Values of the mode flag carried in tuser.
	localparam logic MODE_COMPUTE = 1'b0;
	localparam logic MODE_CLEAR   = 1'b1;

	// Saturation bounds of the 48-bit accumulators.
	localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;

	// Kinds of register settings used by the random phases.
	typedef enum int {
		SET_DEFAULT,
		SET_MODERATE,
		SET_EXTREME_HIGH,
		SET_EXTREME_LOW,
		SET_ANY
	} setting_kind_e;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;
	logic              s_tuser   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data  = '0;

	// Predictor copy of the registers and the stored state.
	pidfd_cfg_t cfg_model = '{RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN, RST_LIMIT_LOW,
		RST_LIMIT_HIGH, RST_PERIOD, RST_ALPHA};
	longint integ_acc  = 0;
	longint prev_error = 0;
	longint slope_filt = 0;

	logic [DATA_W-1:0] expected_outputs[$];
	int mismatch_count = 0;
	bit sender_quiet   = 1'b0;
	bit sink_quiet     = 1'b0;
	int sink_hold_left = 0;

	pid_controller_filtered_derivative DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Counts a failure and reports the first few of them.
	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	function automatic longint saturate_acc(longint v);
		if (v > ACC_HI) return ACC_HI;
		if (v < ACC_LO) return ACC_LO;
		return v;
	endfunction

	// Applies a sign to a magnitude and clamps it to the accumulator range.
	function automatic longint signed_magnitude(logic [127:0] m, bit neg);
		if (m > 128'(ACC_HI)) return neg ? ACC_LO : ACC_HI;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	// Exact product, shifted right with truncation toward zero, then saturated.
	function automatic longint fixed_product(longint a, longint b, int sh);
		logic [127:0] p;
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		return signed_magnitude(p >> sh, (a < 0) != (b < 0));
	endfunction

	// Works out the control output of one accepted transaction and queues it.
	function automatic void predict_control(logic mode, logic [DATA_W-1:0] target,
			logic [DATA_W-1:0] measured);
		longint err, p_term, i_term, d_term, raw_slope, diff, total, alpha, lim_lo, lim_hi;
		logic [63:0] diff_mag, period;
		if (mode == MODE_CLEAR) begin
			integ_acc  = 0;
			prev_error = 0;
			slope_filt = 0;
			return;
		end
		period = 64'(cfg_model.sample_period);
		lim_lo = longint'($signed(cfg_model.limit_low));
		lim_hi = longint'($signed(cfg_model.limit_high));
		err = longint'($signed(target)) - longint'($signed(measured));
		p_term = fixed_product(longint'($signed(cfg_model.prop_gain)), err, FRAC_W);

		// Anti-windup: integrate only while P lies strictly inside the limits.
		if (lim_lo < p_term && p_term < lim_hi) begin
			integ_acc = saturate_acc(integ_acc + fixed_product(err, longint'(period), FRAC_W));
		end
		i_term = fixed_product(longint'($signed(cfg_model.integ_gain)), integ_acc, FRAC_W);

		// Raw slope; a zero sample period drives it to the extreme of the difference's sign.
		diff = err - prev_error;
		diff_mag = diff < 0 ? -diff : diff;
		if (diff == 0) begin
			raw_slope = 0;
		end else if (period == 0) begin
			raw_slope = diff < 0 ? ACC_LO : ACC_HI;
		end else begin
			raw_slope = signed_magnitude(128'((diff_mag << FRAC_W) / period), diff < 0);
		end

		// Low-pass filter; alpha above one acts as one.
		alpha = (cfg_model.filter_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE)
			: longint'(cfg_model.filter_alpha);
		slope_filt = saturate_acc(fixed_product(slope_filt, alpha, ALPHA_FRAC)
			+ fixed_product(raw_slope, longint'(ALPHA_ONE) - alpha, ALPHA_FRAC));
		d_term = fixed_product(longint'($signed(cfg_model.deriv_gain)), slope_filt, FRAC_W);

		// Cap at the high limit first, then raise to the low limit.
		total = p_term + i_term + d_term;
		if (total > lim_hi) total = lim_hi;
		if (total < lim_lo) total = lim_lo;
		prev_error = err;
		expected_outputs.push_back(DATA_W'(total));
	endfunction

	// Offers one input transaction, waits until it is taken and predicts its result.
	task automatic send_sample(logic mode, logic [DATA_W-1:0] target, logic [DATA_W-1:0] measured);
		if (!sender_quiet && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 70)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {measured, target};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_control(mode, target, measured);
	endtask

	// Stops offering and waits until every expected result has come.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_outputs.size() != 0) begin
			flag_error($sformatf("%0d expected results never arrived", expected_outputs.size()));
			expected_outputs.delete();
		end
	endtask

	// One register write transaction; valid is left high for a following write.
	task automatic push_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Writes the whole register bank once the block has gone idle.
	task automatic apply_settings(pidfd_cfg_t s);
		wait_for_results();
		repeat (SETTLE_GAP) @(posedge clk);
		push_register(REG_PROP_GAIN, s.prop_gain);
		push_register(REG_INTEG_GAIN, s.integ_gain);
		push_register(REG_DERIV_GAIN, s.deriv_gain);
		push_register(REG_LIMIT_LOW, s.limit_low);
		push_register(REG_LIMIT_HIGH, s.limit_high);
		push_register(REG_PERIOD, s.sample_period);
		// Upper data bits above the alpha field must be ignored.
		push_register(REG_FILTER_ALPHA, {15'($urandom), s.filter_alpha});
		cfg_valid <= 1'b0;
		cfg_model = s;
	endtask

	function automatic pidfd_cfg_t default_settings();
		return '{RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN, RST_LIMIT_LOW,
			RST_LIMIT_HIGH, RST_PERIOD, RST_ALPHA};
	endfunction

	function automatic pidfd_cfg_t random_settings(setting_kind_e kind);
		pidfd_cfg_t s;
		s = default_settings();
		case (kind)
			SET_MODERATE: begin
				s.prop_gain     = DATA_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
				s.integ_gain    = DATA_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
				s.deriv_gain    = DATA_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
				s.limit_low     = DATA_W'(-int'($urandom_range(1 << 16, 1 << 22)));
				s.limit_high    = DATA_W'($urandom_range(1 << 16, 1 << 22));
				s.sample_period = $urandom_range(1, 1 << 17);
				s.filter_alpha  = ALPHA_W'($urandom_range(0, 65536));
			end
			SET_EXTREME_HIGH: begin
				s = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
					32'h7FFF_FFFF, 32'h0000_0001, '0};
			end
			SET_EXTREME_LOW: begin
				s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0,
					32'hFFFF_FFFF, ALPHA_ONE};
			end
			SET_ANY: begin
				s.prop_gain     = $urandom;
				s.integ_gain    = $urandom;
				s.deriv_gain    = $urandom;
				s.limit_low     = $urandom;
				s.limit_high    = $urandom;
				s.sample_period = $urandom_range(1, 32'hFFFF_FFFF);
				s.filter_alpha  = ALPHA_W'($urandom_range(0, 65536));
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	// Level drawn from the whole range, small and medium magnitudes, or the extremes.
	function automatic logic [DATA_W-1:0] random_level();
		case ($urandom_range(3))
			0: return $urandom;
			1: return DATA_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			2: return DATA_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
			default: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	task automatic send_corner_levels();
		send_sample(MODE_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(MODE_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(MODE_COMPUTE, 32'h0001_0000, '0);
		send_sample(MODE_COMPUTE, '0, '0);
	endtask

	// Register defaults straight after reset, with a clear in the middle.
	task automatic test_default_registers();
		send_corner_levels();
		send_sample(MODE_CLEAR, $urandom, $urandom);
		send_sample(MODE_COMPUTE, 32'h0005_0000, 32'h0001_0000);
		send_sample(MODE_COMPUTE, 32'h0005_0000, 32'h0004_8000);
	endtask

	// Crossed limits, alpha above one, zero sample period and extreme registers.
	task automatic test_special_settings();
		pidfd_cfg_t s;
		s = default_settings();
		s.limit_low  = 32'h000A_0000;
		s.limit_high = 32'hFFF6_0000;
		apply_settings(s);
		send_corner_levels();
		s = default_settings();
		s.filter_alpha = 17'h1_FFFF;
		apply_settings(s);
		send_corner_levels();
		s = default_settings();
		s.sample_period = '0;
		apply_settings(s);
		send_corner_levels();
		apply_settings(random_settings(SET_EXTREME_HIGH));
		send_corner_levels();
	endtask

	// The receiver holds off long enough for the block to stall its input.
	task automatic test_output_backpressure();
		int n;
		apply_settings(random_settings(SET_MODERATE));
		sender_quiet   = 1'b1;
		sink_hold_left = 600;
		for (n = 0; n < 12; n++) begin
			send_sample(MODE_COMPUTE, random_level(), random_level());
		end
		sender_quiet = 1'b0;
		wait_for_results();
	endtask

	// Tracking sequences around a drifting setpoint, with clears and unrelated noise.
	task automatic test_random_traffic();
		setting_kind_e order[6] = '{SET_MODERATE, SET_DEFAULT, SET_EXTREME_HIGH, SET_ANY,
			SET_EXTREME_LOW, SET_MODERATE};
		int phase, n;
		int unsigned pick;
		logic [DATA_W-1:0] setpoint;
		for (phase = 0; phase < 6; phase++) begin
			apply_settings(random_settings(order[phase]));
			sender_quiet = (phase == 5);
			sink_quiet   = (phase == 5);
			setpoint = random_level();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) begin
					wait_for_results();
				end
				pick = $urandom_range(99);
				if (pick < 5) begin
					send_sample(MODE_CLEAR, $urandom, $urandom);
				end else if (pick < 15) begin
					send_sample(MODE_COMPUTE, random_level(), random_level());
				end else begin
					if ($urandom_range(31) == 0) setpoint = random_level();
					send_sample(MODE_COMPUTE, setpoint,
						setpoint - DATA_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17)));
				end
			end
		end
		sender_quiet = 1'b0;
		sink_quiet   = 1'b0;
	endtask

	// Receiver pacing: random stalls, quiet stretches and requested long hold-offs.
	initial begin : sink_pacing
		forever begin
			@(posedge clk);
			if (sink_hold_left > 0) begin
				sink_hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= sink_quiet || ($urandom_range(99) >= 14);
			end
		end
	end

	// Compares each result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		logic [DATA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_outputs.size() == 0) begin
				flag_error($sformatf("control_output %h arrived with nothing expected", m_tdata));
			end else begin
				want = expected_outputs.pop_front();
				if (m_tdata !== want) begin
					flag_error($sformatf("control_output expected %h actual %h", want, m_tdata));
				end
			end
		end
	end

	initial begin : watchdog
		#(CLK_PERIOD * 1_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_default_registers();
		test_special_settings();
		test_output_backpressure();
		test_random_traffic();
		wait_for_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- pid_controller_filtered_derivative.f -----
src/pidfd_pkg.sv
src/pidfd_div.sv
src/pidfd_datapath.sv
src/pidfd_ctrl.sv
src/pid_controller_filtered_derivative.sv
bench/pid_controller_filtered_derivative_tb.sv
